>>> rtl/core/histeq_pkg.sv
// ----------------------------------------------------------------------------
// histeq_pkg
// Shared types and constants of the histogram equalizer.
// ----------------------------------------------------------------------------
package histeq_pkg;

    localparam int COUNT_BITS = 22;
    localparam int NUM_BINS   = 256;
    localparam int BIN_BITS   = 8;
    localparam int PIX_BITS   = 8;
    localparam int FUNC_BITS  = 2;
    localparam int MAX_LEVEL  = 255;
    // numerator (cdf - min) * 255 fits COUNT_BITS + 8 bits
    localparam int NUM_BITS   = COUNT_BITS + 8;
    localparam int QDEPTH     = 4;
    localparam int QPTR_BITS  = 2;

    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [PIX_BITS-1:0]   t_pixel;

    typedef enum logic [FUNC_BITS-1:0] {
        FUNC_COUNT = 2'd0,
        FUNC_BUILD = 2'd1,
        FUNC_MAP   = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    // command from the front end to the back end
    typedef struct packed {
        t_func  func;
        t_pixel pixel;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_INC,
        ST_CLEAR,
        ST_MIN,
        ST_MIN_LAST,
        ST_BUILD,
        ST_DIV
    } t_state;

endpackage

>>> rtl/core/histeq_if.sv
// ----------------------------------------------------------------------------
// histeq_in_if / histeq_out_if
// Valid/ready channels of the histogram equalizer.
// ----------------------------------------------------------------------------
interface histeq_in_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                func;
    logic [7:0]                pixel_in;
    modport source (output valid, output func, output pixel_in, input ready);
    modport sink   (input valid, input func, input pixel_in, output ready);
endinterface

interface histeq_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_out;
    logic       truncated;
    modport source (output valid, output pixel_out, output truncated, input ready);
    modport sink   (input valid, input pixel_out, input truncated, output ready);
endinterface

>>> rtl/core/histeq_front.sv
// ----------------------------------------------------------------------------
// histeq_front
// Accepts items, drops unused codes and queues commands for the back end.
// ----------------------------------------------------------------------------
module histeq_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    histeq_in_if.sink           in_ch,
    output histeq_pkg::t_cmd    o_cmd,
    output logic                o_cmd_valid,
    input  logic                i_cmd_pop
);
    import histeq_pkg::*;

    t_cmd                 r_q [QDEPTH];
    logic [QPTR_BITS-1:0] r_wr, r_rd;
    logic [QPTR_BITS:0]   r_cnt;
    logic                 push, pop;
    t_func                func;

    assign func        = t_func'(in_ch.func);
    assign in_ch.ready = (r_cnt != (QPTR_BITS+1)'(QDEPTH));
    // unused code is taken and discarded
    assign push        = in_ch.valid && in_ch.ready && (func != FUNC_NONE);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rd];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= '{func: func, pixel: in_ch.pixel_in};
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QPTR_BITS+1)'(QDEPTH))
        else $error("queue overfilled");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> !pop)
        else $error("pop from empty queue");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == (QPTR_BITS+1)'(QDEPTH)) |-> !push)
        else $error("push into full queue");

endmodule

>>> rtl/core/histeq_div.sv
// ----------------------------------------------------------------------------
// histeq_div
// Restoring divider, one quotient bit per cycle: (2*num+den) / (2*den).
// ----------------------------------------------------------------------------
module histeq_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [histeq_pkg::NUM_BITS-1:0]   i_num,
    input  histeq_pkg::t_count                i_den,
    output logic                              o_done,
    output histeq_pkg::t_pixel                o_level
);
    import histeq_pkg::*;

    localparam int DW = NUM_BITS + 2;
    localparam int SW = $clog2(DW + 1);

    logic [DW-1:0] r_dvd, n_dvd;
    logic [DW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_dsr;
    logic [SW-1:0] r_step;
    logic          r_busy;
    logic [DW-1:0] trial;

    // shift one dividend bit into the remainder and try a subtract
    always_comb begin
        trial = {r_rem[DW-2:0], r_dvd[DW-1]};
        n_dvd = {r_dvd[DW-2:0], 1'b0};
        if (trial >= r_dsr) begin
            n_rem    = trial - r_dsr;
            n_dvd[0] = 1'b1;
        end else begin
            n_rem = trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_step <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= SW'(DW);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == SW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= DW'({i_num, 1'b0}) + DW'(i_den);
            r_rem <= '0;
            r_dsr <= DW'({i_den, 1'b0});
        end else if (r_busy) begin
            r_dvd <= n_dvd;
            r_rem <= n_rem;
        end
    end

    // quotient saturates at the top level
    assign o_level = (r_dvd > DW'(MAX_LEVEL)) ? PIX_BITS'(MAX_LEVEL) : r_dvd[PIX_BITS-1:0];

endmodule

>>> rtl/core/histeq_back.sv
// ----------------------------------------------------------------------------
// histeq_back
// Histogram counting, map build sequencer and map lookup.
// ----------------------------------------------------------------------------
module histeq_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  histeq_pkg::t_cmd    i_cmd,
    input  logic                i_cmd_valid,
    output logic                o_cmd_pop,
    histeq_out_if.source        out_ch
);
    import histeq_pkg::*;

    t_state r_state, n_state;

    t_count r_bins [NUM_BINS];
    t_pixel r_map  [NUM_BINS];
    t_count r_total;
    logic   r_phase, r_drop;

    logic [BIN_BITS-1:0] r_idx;
    t_count              r_min, r_cdf;
    t_count              r_bin_q;
    logic [BIN_BITS-1:0] rd_addr;
    t_count              cdf_next;

    // output register
    logic   r_ov;
    t_pixel r_opix;
    logic   r_otr;

    logic   div_start, div_done;
    t_pixel div_level;
    logic [NUM_BITS-1:0] num;
    t_count              den;
    logic                is_cnt, full;
    logic                out_free;

    assign out_free  = !r_ov || out_ch.ready;
    assign is_cnt    = (i_cmd.func == FUNC_COUNT) || (i_cmd.func == FUNC_BUILD);
    assign cdf_next  = r_cdf + r_bin_q;
    assign den       = (r_total > r_min) ? (r_total - r_min) : '0;
    assign num       = NUM_BITS'(cdf_next - r_min) * NUM_BITS'(MAX_LEVEL);
    assign full      = (r_total == {COUNT_BITS{1'b1}});

    assign out_ch.valid     = r_ov;
    assign out_ch.pixel_out = r_opix;
    assign out_ch.truncated = r_otr;

    histeq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num),
        .i_den   (den),
        .o_done  (div_done),
        .o_level (div_level)
    );

    // next state and pop
    always_comb begin
        n_state   = r_state;
        o_cmd_pop = 1'b0;
        div_start = 1'b0;
        unique case (r_state)
            ST_RUN: begin
                if (i_cmd_valid) begin
                    if (is_cnt && r_phase) begin
                        n_state = ST_CLEAR;
                    end else if (is_cnt) begin
                        n_state = ST_INC;
                    end else if (i_cmd.func == FUNC_MAP) begin
                        o_cmd_pop = out_free;
                    end else begin
                        o_cmd_pop = 1'b1;
                    end
                end
            end
            ST_INC: begin
                o_cmd_pop = 1'b1;
                n_state   = (i_cmd.func == FUNC_BUILD) ? ST_MIN : ST_RUN;
            end
            ST_CLEAR:    if (r_idx == BIN_BITS'(NUM_BINS-1)) n_state = ST_RUN;
            ST_MIN:      if (r_idx == BIN_BITS'(NUM_BINS-1)) n_state = ST_MIN_LAST;
            ST_MIN_LAST: n_state = ST_BUILD;
            ST_BUILD: begin
                if (den != '0 && cdf_next >= r_min) begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end else if (r_idx == BIN_BITS'(NUM_BINS-1)) begin
                    n_state = ST_RUN;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = (r_idx == BIN_BITS'(NUM_BINS-1)) ? ST_RUN : ST_BUILD;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_CLEAR;
        else          r_state <= n_state;
    end

    // bin read address: counted pixel, scan index, or next entry of the build
    always_comb begin
        case (r_state) inside
            ST_MIN, ST_MIN_LAST: rd_addr = r_idx;
            ST_BUILD, ST_DIV:    rd_addr = r_idx + 1'b1;
            default:             rd_addr = i_cmd.pixel;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_total <= '0;
            r_phase <= 1'b0;
            r_drop  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_ov <= (r_ov && !out_ch.ready) || (o_cmd_pop && i_cmd.func == FUNC_MAP);
            case (r_state)
                ST_RUN: begin
                    r_idx <= '0;
                    r_cdf <= '0;
                end
                ST_INC: begin
                    if (full) r_drop <= 1'b1;
                    else      r_total <= r_total + 1'b1;
                end
                ST_CLEAR: begin
                    r_idx   <= r_idx + 1'b1;
                    r_total <= '0;
                    r_drop  <= 1'b0;
                    if (r_idx == BIN_BITS'(NUM_BINS-1)) r_phase <= 1'b0;
                end
                ST_MIN: begin
                    r_idx <= r_idx + 1'b1;
                end
                ST_MIN_LAST: begin
                    r_idx <= '0;
                end
                ST_BUILD: begin
                    r_cdf <= cdf_next;
                    if (n_state != ST_DIV) r_idx <= r_idx + 1'b1;
                    if (n_state == ST_RUN) r_phase <= 1'b1;
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_idx <= r_idx + 1'b1;
                        if (r_idx == BIN_BITS'(NUM_BINS-1)) r_phase <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath: minimum over the registered bin reads, output payload
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_MIN && r_idx != '0) || r_state == ST_MIN_LAST) begin
            if ((r_state == ST_MIN && r_idx == BIN_BITS'(1)) || r_bin_q < r_min) begin
                r_min <= r_bin_q;
            end
        end
        if (r_state == ST_RUN && o_cmd_pop && i_cmd.func == FUNC_MAP) begin
            r_opix <= r_map[i_cmd.pixel];
            r_otr  <= r_drop;
        end
    end

    // bin memory: clear sweep, increment, registered read
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLEAR) begin
            r_bins[r_idx] <= '0;
        end else if (r_state == ST_INC && !full) begin
            r_bins[i_cmd.pixel] <= r_bin_q + 1'b1;
        end
        r_bin_q <= r_bins[rd_addr];
    end

    // level map memory
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLEAR && !r_phase) begin
            r_map[r_idx] <= '0;
        end else if (r_state == ST_BUILD && n_state != ST_DIV) begin
            r_map[r_idx] <= '0;
        end else if (r_state == ST_DIV && div_done) begin
            r_map[r_idx] <= div_level;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !out_ch.ready) |=> r_ov)
        else $error("result lost");
    a_pop_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (r_state == ST_RUN) || (r_state == ST_INC))
        else $error("pop outside run");
    a_div_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> (r_state == ST_BUILD) && (den != '0))
        else $error("bad divide start");

endmodule

>>> rtl/core/histogram_equalizer.sv
// ----------------------------------------------------------------------------
// histogram_equalizer
// Two-pass 8-bit greyscale histogram equalization.
// ----------------------------------------------------------------------------
// Count items go through a bin read, then an increment, in the back end, and
// map items are taken straight from the run state when the output register
// is free. A build item counts its pixel, then holds the back end for the
// minimum search and the map build, one map entry at a time; every entry
// goes through the bit-serial divider unless the total equals the smallest
// bin. The first count item after a build sweeps the 256 bins clear before
// it counts. After reset a clearing pass runs before the first item is
// executed; inputs are queued meanwhile up to four deep.
module histogram_equalizer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    histeq_in_if.sink    in_ch,
    histeq_out_if.source out_ch
);
    import histeq_pkg::*;

    t_cmd cmd;
    logic cmd_valid, cmd_pop;

    histeq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_ch       (in_ch),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    histeq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .out_ch      (out_ch)
    );

endmodule
